// ----- rtl/i2c_lsr_pkg.sv -----
`default_nettype none

package i2c_lsr_pkg;

   // Number of bytes read in a measurement. Only the first two form the raw value.
   localparam int unsigned READ_BYTES = 3;

   localparam int unsigned OP_W      = 2;
   localparam int unsigned CMD_W     = 8;
   localparam int unsigned ADDR_W    = 7;
   localparam int unsigned HALF_W    = 8;
   localparam int unsigned LUX_W     = 16;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   // floor(5*raw/6) = raw - ceil(raw/6), with ceil(raw/6) = floor((raw+5)/6).
   // The quotient uses a reciprocal that is exact for all 17-bit dividends.
   localparam logic [17:0] LUX_RECIP = 18'd174763;
   localparam int unsigned LUX_SHIFT = 20;
   localparam logic [16:0] LUX_ROUND = 17'd5;

   localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd35;
   localparam logic [HALF_W-1:0] HALF_RESET = 8'd20;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_HALF_PERIOD    = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_START_A = 5'd1,
      PH_START_B = 5'd2,
      PH_TX_LO   = 5'd3,
      PH_TX_HI   = 5'd4,
      PH_TACK_LO = 5'd5,
      PH_TACK_HI = 5'd6,
      PH_RX_LO   = 5'd7,
      PH_RX_HI   = 5'd8,
      PH_MACK_LO = 5'd9,
      PH_MACK_HI = 5'd10,
      PH_STOP_A  = 5'd11,
      PH_STOP_B  = 5'd12,
      PH_STOP_C  = 5'd13
   } phase_type;

endpackage

`default_nettype wire

// ----- rtl/i2c_light_sensor_reader_core.sv -----
// A response beat is registered and appears in the cycle after its request beat
// is accepted. One request beat per clock is taken while the response side keeps
// up; each beat is one bus timing tick and yields exactly one response beat.
// Reset (synchronous, active high) returns the sequencer to idle with both lines
// released, clears the reading and lux registers, and restores address 35 and a
// half period of 20 ticks. There is no clearing pass.
`default_nettype none

module i2c_light_sensor_reader_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: command_byte [7:0], sda_in [8], zero padding [15:9].
   input  wire logic [i2c_lsr_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: operation [1:0].
   input  wire logic [i2c_lsr_pkg::OP_W-1:0]       req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: scl_level [0], sda_pull_low [1], busy_res [2], lux_value [18:3],
   // zero padding [23:19].
   output logic [i2c_lsr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tlast: done_res, high on the final tick of a transaction.
   output logic             rsp_tlast,
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);

   import i2c_lsr_pkg::*;

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are taken on any cycle.
   // ------------------------------------------------------------------------
   logic [ADDR_W-1:0] dev_addr_ff;
   logic [HALF_W-1:0] half_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= ADDR_RESET;
         half_ff     <= HALF_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_data[ADDR_W-1:0];
            CSR_HALF_PERIOD:    half_ff     <= csr_data;
            default:            ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer state.
   // ------------------------------------------------------------------------
   phase_type        phase_ff, phase_in;
   logic [7:0]       delay_ff, delay_in;
   logic [2:0]       bit_ff, bit_in;
   logic [1:0]       byte_ff, byte_in;
   logic [7:0]       shift_ff, shift_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic             read_mode_ff, read_mode_in;
   logic [LUX_W-1:0] raw_ff, raw_in;
   logic [LUX_W-1:0] lux_ff, lux_in;
   logic [LUX_W-1:0] quot_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff;

   op_type           req_op;
   logic [CMD_W-1:0] req_cmd;
   logic             req_sda;
   logic             accept;

   logic             scl_lvl;
   logic             sda_pull;
   logic             busy;
   logic             done;
   logic [8:0]       delay_inc;
   logic [HALF_W-1:0] half_eff;

   assign req_op  = op_type'(req_tuser);
   assign req_cmd = req_tdata[CMD_W-1:0];
   assign req_sda = req_tdata[CMD_W];

   // The response register frees up in the same cycle it is drained, so a new
   // tick is taken every cycle the downstream side keeps up.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // A zero half period behaves as one tick per slot.
   assign half_eff = (half_ff == '0) ? HALF_W'(1) : half_ff;

   // The lux quotient is formed every clock from the stored reading. The reading
   // is last updated in a receive slot, at least three ticks before the final
   // stop slot ends, so the quotient has settled by the time it is used.
   logic [16:0] raw_plus;
   logic [34:0] quot_prod;

   assign raw_plus  = {1'b0, raw_ff} + LUX_ROUND;
   assign quot_prod = 35'(raw_plus) * 35'(LUX_RECIP);

   always_ff @(posedge clock) begin
      quot_ff <= LUX_W'(quot_prod >> LUX_SHIFT);
   end

   // ------------------------------------------------------------------------
   // Next state and line levels for one tick.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      delay_in     = delay_ff;
      bit_in       = bit_ff;
      byte_in      = byte_ff;
      shift_in     = shift_ff;
      cmd_in       = cmd_ff;
      read_mode_in = read_mode_ff;
      raw_in       = raw_ff;
      lux_in       = lux_ff;
      scl_lvl      = 1'b1;
      sda_pull     = 1'b0;
      done         = 1'b0;
      delay_inc    = '0;

      // An undefined phase falls back to idle before anything else happens.
      if (phase_ff > PH_STOP_C) begin
         phase_in = PH_IDLE;
      end

      // A request in idle starts the transaction on this very tick.
      if (phase_in == PH_IDLE && (req_op == OP_WRITE || req_op == OP_READ)) begin
         read_mode_in = (req_op == OP_READ);
         if (req_op == OP_WRITE) begin
            cmd_in = req_cmd;
         end
         byte_in  = '0;
         bit_in   = '0;
         delay_in = '0;
         phase_in = PH_START_A;
      end

      case (phase_in)
         PH_START_A: begin scl_lvl = 1'b1; sda_pull = 1'b0; end
         PH_START_B: begin scl_lvl = 1'b1; sda_pull = 1'b1; end
         PH_TX_LO:   begin scl_lvl = 1'b0; sda_pull = ~shift_in[7]; end
         PH_TX_HI:   begin scl_lvl = 1'b1; sda_pull = ~shift_in[7]; end
         PH_TACK_LO: begin scl_lvl = 1'b0; sda_pull = 1'b0; end
         PH_TACK_HI: begin scl_lvl = 1'b1; sda_pull = 1'b0; end
         PH_RX_LO:   begin scl_lvl = 1'b0; sda_pull = 1'b0; end
         PH_RX_HI:   begin scl_lvl = 1'b1; sda_pull = 1'b0; end
         PH_MACK_LO: begin
            scl_lvl  = 1'b0;
            sda_pull = (byte_in < 2'(READ_BYTES - 1));
         end
         PH_MACK_HI: begin
            scl_lvl  = 1'b1;
            sda_pull = (byte_in < 2'(READ_BYTES - 1));
         end
         PH_STOP_A:  begin scl_lvl = 1'b0; sda_pull = 1'b1; end
         PH_STOP_B:  begin scl_lvl = 1'b1; sda_pull = 1'b1; end
         PH_STOP_C:  begin scl_lvl = 1'b1; sda_pull = 1'b0; end
         default:    begin scl_lvl = 1'b1; sda_pull = 1'b0; end
      endcase

      busy = (phase_in != PH_IDLE);

      if (busy) begin
         delay_inc = {1'b0, delay_in} + 9'd1;
         if (delay_inc < {1'b0, half_eff}) begin
            delay_in = delay_inc[7:0];
         end else begin
            delay_in = '0;
            case (phase_in)
               PH_START_A: phase_in = PH_START_B;
               PH_START_B: begin
                  // Address byte with the read/write flag as its lsb.
                  byte_in  = '0;
                  shift_in = {dev_addr_ff, read_mode_in};
                  bit_in   = '0;
                  phase_in = PH_TX_LO;
               end
               PH_TX_LO: phase_in = PH_TX_HI;
               PH_TX_HI: begin
                  if (bit_in == 3'd7) begin
                     phase_in = PH_TACK_LO;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     shift_in = {shift_in[6:0], 1'b0};
                     phase_in = PH_TX_LO;
                  end
               end
               PH_TACK_LO: phase_in = PH_TACK_HI;
               PH_TACK_HI: begin
                  // The slave's acknowledge is not checked.
                  if (read_mode_in) begin
                     byte_in  = '0;
                     shift_in = '0;
                     bit_in   = '0;
                     phase_in = PH_RX_LO;
                  end else if (byte_in == 2'd0) begin
                     byte_in  = 2'd1;
                     shift_in = cmd_in;
                     bit_in   = '0;
                     phase_in = PH_TX_LO;
                  end else begin
                     phase_in = PH_STOP_A;
                  end
               end
               PH_RX_LO: phase_in = PH_RX_HI;
               PH_RX_HI: begin
                  shift_in = {shift_in[6:0], req_sda};
                  if (bit_in == 3'd7) begin
                     // First byte is the high half, second the low half.
                     if (byte_in == 2'd0) begin
                        raw_in[15:8] = shift_in;
                     end else if (byte_in == 2'd1) begin
                        raw_in[7:0] = shift_in;
                     end
                     phase_in = PH_MACK_LO;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PH_RX_LO;
                  end
               end
               PH_MACK_LO: phase_in = PH_MACK_HI;
               PH_MACK_HI: begin
                  if (byte_in >= 2'(READ_BYTES - 1)) begin
                     phase_in = PH_STOP_A;
                  end else begin
                     byte_in  = byte_in + 2'd1;
                     shift_in = '0;
                     bit_in   = '0;
                     phase_in = PH_RX_LO;
                  end
               end
               PH_STOP_A: phase_in = PH_STOP_B;
               PH_STOP_B: phase_in = PH_STOP_C;
               default: begin
                  if (read_mode_in) begin
                     lux_in = raw_ff - quot_ff;
                  end
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      rsp_data_in = {5'd0, lux_in, busy, sda_pull, scl_lvl};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         delay_ff     <= '0;
         bit_ff       <= '0;
         byte_ff      <= '0;
         shift_ff     <= '0;
         cmd_ff       <= '0;
         read_mode_ff <= 1'b0;
         raw_ff       <= '0;
         lux_ff       <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         delay_ff     <= delay_in;
         bit_ff       <= bit_in;
         byte_ff      <= byte_in;
         shift_ff     <= shift_in;
         cmd_ff       <= cmd_in;
         read_mode_ff <= read_mode_in;
         raw_ff       <= raw_in;
         lux_ff       <= lux_in;
      end
   end

   // Response register: loaded on every accepted tick, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The end-of-transaction beat is always reported as busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_data_ff[2])
      else $error("done beat without busy");

   // An idle tick with no start request leaves both lines released.
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_IDLE && req_op != OP_WRITE && req_op != OP_READ
      |=> rsp_data_ff[0] && !rsp_data_ff[1] && !rsp_data_ff[2] && !rsp_last_ff)
      else $error("idle tick drove the bus");

   // The lux value only moves on the tick that finishes a transaction.
   assert property (@(posedge clock) disable iff (reset)
      accept && !done |=> lux_ff == $past(lux_ff))
      else $error("lux changed outside transaction end");

   // A write transaction never touches the lux value.
   assert property (@(posedge clock) disable iff (reset)
      accept && !read_mode_in |=> lux_ff == $past(lux_ff))
      else $error("lux changed on write transaction");

endmodule

`default_nettype wire
